// ===== src/mcpt_pkg.sv =====
package mcpt_pkg;

	localparam logic [2:0]  KIND_TICK       = 3'd0;
	localparam logic [2:0]  KIND_CREATE     = 3'd1;
	localparam logic [2:0]  KIND_START      = 3'd2;
	localparam logic [2:0]  KIND_RESTART    = 3'd3;
	localparam logic [2:0]  KIND_STOP       = 3'd4;
	localparam logic [31:0] INTERVAL_REJECT = 32'hFFFF_FFFF;
	localparam logic        STATUS_OK       = 1'b0;
	localparam logic        STATUS_REJECT   = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  timer_index;
		logic [31:0] interval;
		logic        has_action;
	} in_item_t;

	typedef struct packed {
		logic [7:0] fired_mask;
		logic       status;
		logic [2:0] assigned_index;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} seq_state_t;

	typedef struct packed {
		logic ready;
		logic walk;
		logic load_out;
	} seq_ctrl_t;

endpackage

// ===== src/mcpt_unit.sv =====
module mcpt_unit
	import mcpt_pkg::*;
(
	input  logic [31:0] count,
	input  logic [31:0] divider,
	output logic        hit,
	output logic [31:0] next_count
);

	// shared compare / increment used once per walked timer
	assign hit        = (count == divider);
	assign next_count = hit ? 32'd0 : count + 32'd1;

endmodule

// ===== src/mcpt_seq.sv =====
module mcpt_seq
	import mcpt_pkg::*;
#(
	parameter int IW = 3,
	parameter int CW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          is_tick,
	input  logic [CW-1:0] in_use,
	input  logic          out_free,
	output seq_ctrl_t     ctrl,
	output logic [IW-1:0] idx
);

	seq_state_t state_q, state_d;
	logic [IW-1:0] idx_q;
	logic accept, last;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign last   = ((CW'(idx_q) + CW'(1)) == in_use);
	assign idx    = idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_tick && (in_use != '0)) state_d = ST_WALK;
					else state_d = ST_FIN;
				end
			end
			ST_WALK: begin
				if (last) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: ctrl.ready    = 1'b1;
			ST_WALK: ctrl.walk     = 1'b1;
			ST_FIN:  ctrl.load_out = out_free;
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) idx_q <= '0;
			else if (state_q == ST_WALK && !last) idx_q <= idx_q + IW'(1);
		end
	end

endmodule

// ===== src/multi_channel_periodic_timer_top.sv =====
// Periodic timer bank.
// Input channel (in_valid/in_ready/in_item): one transaction per command:
//   tick, create, start, restart or stop. Output channel
//   (out_valid/out_ready/out_item): exactly one result per command, in order.
// Sequencing: start/restart/stop/create and ticks with no timers allocated go
//   from acceptance straight to the finish state. A tick first walks the timers:
//   one compare/increment unit walks the allocated timers, one per
//   cycle, and then finishes. The finish state loads the output register once
//   it is free; in_ready is low while a command is in progress.
// The result sits in an output register; a new command is accepted while it
//   waits. If the receiver stalls, the next result is held internally and the
//   block stops accepting until the output register drains.
// Reset (arst_n low) clears the allocation count and all flags; no timers are
//   allocated afterward. No clearing pass is needed.
module multi_channel_periodic_timer_top
	import mcpt_pkg::*;
#(
	parameter int NUM_TIMERS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam int XW = (CW > 3) ? CW : 3;

	logic [CW-1:0]   in_use_q;
	logic [31:0]     divider_q [NUM_TIMERS];
	logic [31:0]     count_q   [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] running_q;
	logic [NUM_TIMERS-1:0] action_q;

	logic [7:0] mask_q;
	logic       status_q;
	logic [2:0] assigned_q;
	out_item_t  out_q;
	logic       out_valid_q;

	seq_ctrl_t     ctrl;
	logic [IW-1:0] idx;
	logic          accept, out_free, hit, valid_idx, full, is_tick;
	logic [31:0]   next_count;
	logic [IW-1:0] cmd_idx, new_idx;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = ctrl.ready;
	assign accept    = in_valid && ctrl.ready;
	assign is_tick   = (in_item.kind == KIND_TICK);
	assign valid_idx = (XW'(in_item.timer_index) < XW'(in_use_q));
	assign full      = (in_use_q == CW'(NUM_TIMERS));
	assign cmd_idx   = IW'(in_item.timer_index);
	assign new_idx   = IW'(in_use_q);

	mcpt_seq #(.IW(IW), .CW(CW)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.is_tick  (is_tick),
		.in_use   (in_use_q),
		.out_free (out_free),
		.ctrl     (ctrl),
		.idx      (idx)
	);

	mcpt_unit u_unit (
		.count      (count_q[idx]),
		.divider    (divider_q[idx]),
		.hit        (hit),
		.next_count (next_count)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			running_q <= '0;
			action_q  <= '0;
		end else if (accept) begin
			case (in_item.kind)
				KIND_CREATE: begin
					if (in_item.interval != INTERVAL_REJECT && !full) begin
						running_q[new_idx] <= 1'b0;
						action_q[new_idx]  <= in_item.has_action;
						in_use_q           <= in_use_q + CW'(1);
					end
				end
				KIND_START, KIND_RESTART: begin
					if (valid_idx) running_q[cmd_idx] <= 1'b1;
				end
				KIND_STOP: begin
					if (valid_idx) running_q[cmd_idx] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// timer tables
	always_ff @(posedge clk) begin
		if (accept) begin
			case (in_item.kind)
				KIND_CREATE: begin
					if (in_item.interval != INTERVAL_REJECT && !full) begin
						divider_q[new_idx] <= in_item.interval;
						count_q[new_idx]   <= 32'd0;
					end
				end
				KIND_RESTART: begin
					if (valid_idx) count_q[cmd_idx] <= 32'd0;
				end
				default: ;
			endcase
		end else if (ctrl.walk && running_q[idx]) begin
			count_q[idx] <= next_count;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q     <= '0;
			assigned_q <= '0;
			status_q   <= STATUS_OK;
			case (in_item.kind)
				KIND_TICK: ;
				KIND_CREATE: begin
					if (in_item.interval == INTERVAL_REJECT || full) status_q <= STATUS_REJECT;
					else assigned_q <= 3'(in_use_q);
				end
				KIND_START, KIND_RESTART, KIND_STOP: begin
					if (!valid_idx) status_q <= STATUS_REJECT;
				end
				default: status_q <= STATUS_REJECT;
			endcase
		end else if (ctrl.walk && running_q[idx] && hit && action_q[idx]
				&& (32'(idx) < 32'd8)) begin
			mask_q[3'(idx)] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			out_q.fired_mask     <= mask_q;
			out_q.status         <= status_q;
			out_q.assigned_index <= assigned_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ctrl.load_out) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== src/mcpt_checker.sv =====
module mcpt_checker
	import mcpt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a command while one is in progress");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status == STATUS_REJECT)
		|-> (out_item.fired_mask == 8'd0) && (out_item.assigned_index == 3'd0))
		else $error("rejected command reports mask or index");

endmodule

bind multi_channel_periodic_timer_top mcpt_checker u_mcpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
